>>> hdl/multi_cpu_job_dispatcher_macros.svh
// assertion macros for the job dispatcher
`ifndef MULTI_CPU_JOB_DISPATCHER_MACROS_SVH
`define MULTI_CPU_JOB_DISPATCHER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MCJD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define MCJD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define MCJD_ASSERT(lbl, prop, msg)

`define MCJD_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

>>> hdl/mcjd_pkg.sv
package mcjd_pkg;

  localparam int MAX_CPUS          = 8;
  localparam int CPU_FIFO_DEPTH    = 16;
  localparam int SHARED_FIFO_DEPTH = 64;

  localparam int CPU_W   = 3;
  localparam int CNT_W   = 4;
  localparam int TAG_W   = 16;
  localparam int SVC_W   = 32;
  localparam int DONE_W  = 16;
  localparam int JOB_W   = TAG_W + SVC_W;

  localparam int CPU_PTR_W  = $clog2(CPU_FIFO_DEPTH);
  localparam int CPU_FILL_W = $clog2(CPU_FIFO_DEPTH + 1);
  localparam int SH_PTR_W   = $clog2(SHARED_FIFO_DEPTH);
  localparam int SH_FILL_W  = $clog2(SHARED_FIFO_DEPTH + 1);
  localparam int CPU_RAM_DEPTH = MAX_CPUS * CPU_FIFO_DEPTH;
  localparam int CPU_RAM_AW    = $clog2(CPU_RAM_DEPTH);

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_DISPATCH_MODE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CPUS_IN_USE   = 1'd1;

  typedef enum logic {OP_ARRIVAL, OP_DEPARTURE} op_t;
  typedef enum logic {MODE_PER_CPU, MODE_SHARED} mode_t;
  typedef enum logic [1:0] {SRC_NONE, SRC_CPU_FIFO, SRC_SHARED_FIFO} src_t;

  typedef struct packed {
    mode_t            mode;
    logic [CNT_W-1:0] cpus;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic [TAG_W-1:0] tag;
    logic [SVC_W-1:0] svc;
    logic [CPU_W-1:0] idx;
  } item_t;

  typedef struct packed {
    logic              start_valid;
    logic [CPU_W-1:0]  start_cpu;
    logic [TAG_W-1:0]  start_tag;
    logic [SVC_W-1:0]  start_service;
    src_t              src;
    logic              was_queued;
    logic              was_dropped;
    logic              went_idle;
    logic              bad_departure;
    logic [DONE_W-1:0] done_count;
  } res_t;

  typedef struct packed {
    logic                  we;
    logic [CPU_RAM_AW-1:0] waddr;
    logic [JOB_W-1:0]      wdata;
    logic                  re;
    logic [CPU_RAM_AW-1:0] raddr;
  } cpu_ram_req_t;

  typedef struct packed {
    logic                we;
    logic [SH_PTR_W-1:0] waddr;
    logic [JOB_W-1:0]    wdata;
    logic                re;
    logic [SH_PTR_W-1:0] raddr;
  } sh_ram_req_t;

endpackage

>>> hdl/multi_cpu_job_dispatcher.sv
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | tuser opcode, tdata tag/service/cpu
// out     | out | out_tvalid/tready  | tdata start info, flags, done count
// cfg     | in  | cfg_we             | cfg_addr register, cfg_wdata value
// one item per cycle; an item is held in the input register, then
// its result sits in the output register, whose queued job comes from the fifo
// ram read port (at most one read per item); a stalled output holds both stages
// synchronous active-low reset clears cpu state and fifo pointers, no ram clear
`include "multi_cpu_job_dispatcher_macros.svh"

module multi_cpu_job_dispatcher (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic                                in_tuser,  // opcode
  // job_tag[15:0], service_time[47:16], cpu_index[50:48], zero pad
  input  logic [mcjd_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // start_valid, start_cpu[3:1], start_tag[19:4], start_service[51:20],
  // was_queued[52], was_dropped[53], went_idle[54], bad_departure[55],
  // done_count[71:56]
  output logic [mcjd_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [mcjd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mcjd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  mcjd_pkg::cfg_t         cfg_r;
  mcjd_pkg::item_t        item_r;
  logic                   in_valid_r;
  mcjd_pkg::res_t         res_r;
  logic                   out_valid_r;
  mcjd_pkg::res_t         res;
  mcjd_pkg::cpu_ram_req_t cpu_req;
  mcjd_pkg::sh_ram_req_t  sh_req;
  logic [mcjd_pkg::JOB_W-1:0] cpu_rdata;
  logic [mcjd_pkg::JOB_W-1:0] sh_rdata;
  logic                   advance;
  logic                   fire;
  logic [mcjd_pkg::TAG_W-1:0] out_tag;
  logic [mcjd_pkg::SVC_W-1:0] out_svc;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= mcjd_pkg::MODE_PER_CPU;
      cfg_r.cpus <= mcjd_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mcjd_pkg::REG_DISPATCH_MODE: cfg_r.mode <= mcjd_pkg::mode_t'(cfg_wdata[0]);
        mcjd_pkg::REG_CPUS_IN_USE:   cfg_r.cpus <= cfg_wdata[mcjd_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.op  <= mcjd_pkg::op_t'(in_tuser);
      item_r.tag <= in_tdata[15:0];
      item_r.svc <= in_tdata[47:16];
      item_r.idx <= in_tdata[50:48];
    end
    if (fire) begin
      res_r <= res;
    end
  end

  mcjd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (item_r),
    .cfg     (cfg_r),
    .res     (res),
    .cpu_req (cpu_req),
    .sh_req  (sh_req)
  );

  mcjd_ram #(
    .WIDTH (mcjd_pkg::JOB_W),
    .DEPTH (mcjd_pkg::CPU_RAM_DEPTH)
  ) u_cpu_ram (
    .clk   (clk),
    .we    (cpu_req.we),
    .waddr (cpu_req.waddr),
    .wdata (cpu_req.wdata),
    .re    (cpu_req.re),
    .raddr (cpu_req.raddr),
    .rdata (cpu_rdata)
  );

  mcjd_ram #(
    .WIDTH (mcjd_pkg::JOB_W),
    .DEPTH (mcjd_pkg::SHARED_FIFO_DEPTH)
  ) u_sh_ram (
    .clk   (clk),
    .we    (sh_req.we),
    .waddr (sh_req.waddr),
    .wdata (sh_req.wdata),
    .re    (sh_req.re),
    .raddr (sh_req.raddr),
    .rdata (sh_rdata)
  );

  always_comb begin
    out_tag = res_r.start_tag;
    out_svc = res_r.start_service;
    unique case (res_r.src)
      mcjd_pkg::SRC_CPU_FIFO: begin
        out_tag = cpu_rdata[mcjd_pkg::JOB_W-1:mcjd_pkg::SVC_W];
        out_svc = cpu_rdata[mcjd_pkg::SVC_W-1:0];
      end
      mcjd_pkg::SRC_SHARED_FIFO: begin
        out_tag = sh_rdata[mcjd_pkg::JOB_W-1:mcjd_pkg::SVC_W];
        out_svc = sh_rdata[mcjd_pkg::SVC_W-1:0];
      end
      mcjd_pkg::SRC_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.done_count, res_r.bad_departure, res_r.went_idle,
                       res_r.was_dropped, res_r.was_queued, out_svc, out_tag,
                       res_r.start_cpu, res_r.start_valid};

  `MCJD_ASSERT(a_one_outcome, !out_tvalid || $countones({out_tdata[0], out_tdata[52], out_tdata[53], out_tdata[54], out_tdata[55]}) == 1, "result must carry exactly one outcome")
  `MCJD_ASSERT(a_ready_when_free, (!out_tvalid || out_tready) |-> in_tready, "input stalled with free output")
  `MCJD_ASSERT_NEXT(a_result_follows, fire, out_tvalid, "processed item gave no result")

endmodule

>>> hdl/mcjd_ram.sv
module mcjd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/mcjd_core.sv
module mcjd_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  mcjd_pkg::item_t       item,
  input  mcjd_pkg::cfg_t        cfg,
  output mcjd_pkg::res_t        res,
  output mcjd_pkg::cpu_ram_req_t cpu_req,
  output mcjd_pkg::sh_ram_req_t sh_req
);

  logic                              busy_r     [mcjd_pkg::MAX_CPUS];
  logic                              busy_nxt   [mcjd_pkg::MAX_CPUS];
  logic [mcjd_pkg::CPU_PTR_W-1:0]    cpu_head_r [mcjd_pkg::MAX_CPUS];
  logic [mcjd_pkg::CPU_PTR_W-1:0]    cpu_head_nxt [mcjd_pkg::MAX_CPUS];
  logic [mcjd_pkg::CPU_FILL_W-1:0]   cpu_fill_r [mcjd_pkg::MAX_CPUS];
  logic [mcjd_pkg::CPU_FILL_W-1:0]   cpu_fill_nxt [mcjd_pkg::MAX_CPUS];
  logic [mcjd_pkg::DONE_W-1:0]       done_r     [mcjd_pkg::MAX_CPUS];
  logic [mcjd_pkg::DONE_W-1:0]       done_nxt   [mcjd_pkg::MAX_CPUS];
  logic [mcjd_pkg::SH_PTR_W-1:0]     sh_head_r, sh_head_nxt;
  logic [mcjd_pkg::SH_FILL_W-1:0]    sh_fill_r, sh_fill_nxt;

  logic [mcjd_pkg::CNT_W-1:0] n_cpus;
  logic                       idx_ok;
  logic                       free_found;
  logic [mcjd_pkg::CPU_W-1:0] free_cpu;

  // active cpu count, clamped
  always_comb begin
    if (cfg.cpus == '0) begin
      n_cpus = mcjd_pkg::CNT_W'(1);
    end else if (cfg.cpus > mcjd_pkg::CNT_W'(mcjd_pkg::MAX_CPUS)) begin
      n_cpus = mcjd_pkg::CNT_W'(mcjd_pkg::MAX_CPUS);
    end else begin
      n_cpus = cfg.cpus;
    end
  end

  assign idx_ok = {1'b0, item.idx} < n_cpus;

  // lowest idle cpu in use
  always_comb begin
    free_found = 1'b0;
    free_cpu   = '0;
    for (int i = mcjd_pkg::MAX_CPUS - 1; i >= 0; i--) begin
      if (mcjd_pkg::CNT_W'(i) < n_cpus && !busy_r[i]) begin
        free_found = 1'b1;
        free_cpu   = mcjd_pkg::CPU_W'(i);
      end
    end
  end

  always_comb begin
    logic [mcjd_pkg::CPU_FILL_W:0]  cpu_sum;
    logic [mcjd_pkg::CPU_PTR_W-1:0] cpu_pos;
    logic [mcjd_pkg::SH_FILL_W:0]   sh_sum;
    logic [mcjd_pkg::SH_PTR_W-1:0]  sh_pos;
    logic                           pop;
    logic [mcjd_pkg::DONE_W-1:0]    done_inc;

    busy_nxt     = busy_r;
    cpu_head_nxt = cpu_head_r;
    cpu_fill_nxt = cpu_fill_r;
    done_nxt     = done_r;
    sh_head_nxt  = sh_head_r;
    sh_fill_nxt  = sh_fill_r;
    res          = '0;
    cpu_req      = '0;
    sh_req       = '0;
    pop          = 1'b0;

    cpu_sum = (mcjd_pkg::CPU_FILL_W + 1)'(cpu_head_r[item.idx])
            + (mcjd_pkg::CPU_FILL_W + 1)'(cpu_fill_r[item.idx]);
    if (cpu_sum >= (mcjd_pkg::CPU_FILL_W + 1)'(mcjd_pkg::CPU_FIFO_DEPTH)) begin
      cpu_sum = cpu_sum - (mcjd_pkg::CPU_FILL_W + 1)'(mcjd_pkg::CPU_FIFO_DEPTH);
    end
    cpu_pos = cpu_sum[mcjd_pkg::CPU_PTR_W-1:0];

    sh_sum = (mcjd_pkg::SH_FILL_W + 1)'(sh_head_r) + (mcjd_pkg::SH_FILL_W + 1)'(sh_fill_r);
    if (sh_sum >= (mcjd_pkg::SH_FILL_W + 1)'(mcjd_pkg::SHARED_FIFO_DEPTH)) begin
      sh_sum = sh_sum - (mcjd_pkg::SH_FILL_W + 1)'(mcjd_pkg::SHARED_FIFO_DEPTH);
    end
    sh_pos = sh_sum[mcjd_pkg::SH_PTR_W-1:0];

    done_inc = (done_r[item.idx] != '1) ? done_r[item.idx] + 1'b1 : done_r[item.idx];

    cpu_req.wdata = {item.tag, item.svc};
    cpu_req.waddr = mcjd_pkg::CPU_RAM_AW'(item.idx)
                  * mcjd_pkg::CPU_RAM_AW'(mcjd_pkg::CPU_FIFO_DEPTH)
                  + mcjd_pkg::CPU_RAM_AW'(cpu_pos);
    cpu_req.raddr = mcjd_pkg::CPU_RAM_AW'(item.idx)
                  * mcjd_pkg::CPU_RAM_AW'(mcjd_pkg::CPU_FIFO_DEPTH)
                  + mcjd_pkg::CPU_RAM_AW'(cpu_head_r[item.idx]);
    sh_req.wdata  = {item.tag, item.svc};
    sh_req.waddr  = sh_pos;
    sh_req.raddr  = sh_head_r;

    if (fire) begin
      unique case (item.op)
        mcjd_pkg::OP_ARRIVAL: begin
          if (cfg.mode == mcjd_pkg::MODE_PER_CPU) begin
            if (!idx_ok) begin
              res.was_dropped = 1'b1;
            end else if (!busy_r[item.idx]) begin
              busy_nxt[item.idx] = 1'b1;
              res.start_valid    = 1'b1;
              res.start_cpu      = item.idx;
              res.start_tag      = item.tag;
              res.start_service  = item.svc;
            end else if (cpu_fill_r[item.idx] >=
                         mcjd_pkg::CPU_FILL_W'(mcjd_pkg::CPU_FIFO_DEPTH)) begin
              res.was_dropped = 1'b1;
            end else begin
              cpu_req.we             = 1'b1;
              cpu_fill_nxt[item.idx] = cpu_fill_r[item.idx] + 1'b1;
              res.was_queued         = 1'b1;
            end
          end else begin
            if (free_found) begin
              busy_nxt[free_cpu] = 1'b1;
              res.start_valid    = 1'b1;
              res.start_cpu      = free_cpu;
              res.start_tag      = item.tag;
              res.start_service  = item.svc;
            end else if (sh_fill_r >= mcjd_pkg::SH_FILL_W'(mcjd_pkg::SHARED_FIFO_DEPTH)) begin
              res.was_dropped = 1'b1;
            end else begin
              sh_req.we      = 1'b1;
              sh_fill_nxt    = sh_fill_r + 1'b1;
              res.was_queued = 1'b1;
            end
          end
        end
        mcjd_pkg::OP_DEPARTURE: begin
          if (!idx_ok || !busy_r[item.idx]) begin
            res.bad_departure = 1'b1;
          end else begin
            if (cfg.mode == mcjd_pkg::MODE_PER_CPU) begin
              if (cpu_fill_r[item.idx] != '0) begin
                pop        = 1'b1;
                cpu_req.re = 1'b1;
                res.src    = mcjd_pkg::SRC_CPU_FIFO;
                cpu_fill_nxt[item.idx] = cpu_fill_r[item.idx] - 1'b1;
                cpu_head_nxt[item.idx] =
                  (cpu_head_r[item.idx] == mcjd_pkg::CPU_PTR_W'(mcjd_pkg::CPU_FIFO_DEPTH - 1))
                  ? '0 : cpu_head_r[item.idx] + 1'b1;
              end
            end else if (sh_fill_r != '0) begin
              pop         = 1'b1;
              sh_req.re   = 1'b1;
              res.src     = mcjd_pkg::SRC_SHARED_FIFO;
              sh_fill_nxt = sh_fill_r - 1'b1;
              sh_head_nxt = (sh_head_r == mcjd_pkg::SH_PTR_W'(mcjd_pkg::SHARED_FIFO_DEPTH - 1))
                          ? '0 : sh_head_r + 1'b1;
            end
            if (pop) begin
              res.start_valid = 1'b1;
              res.start_cpu   = item.idx;
            end else begin
              busy_nxt[item.idx] = 1'b0;
              res.went_idle      = 1'b1;
            end
            done_nxt[item.idx] = done_inc;
            res.done_count     = done_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mcjd_pkg::MAX_CPUS; i++) begin
        busy_r[i]     <= 1'b0;
        cpu_head_r[i] <= '0;
        cpu_fill_r[i] <= '0;
        done_r[i]     <= '0;
      end
      sh_head_r <= '0;
      sh_fill_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      cpu_head_r <= cpu_head_nxt;
      cpu_fill_r <= cpu_fill_nxt;
      done_r     <= done_nxt;
      sh_head_r  <= sh_head_nxt;
      sh_fill_r  <= sh_fill_nxt;
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
  import mcjd_pkg::*;

  typedef struct {
    bit               start_valid;
    bit [CPU_W-1:0]   start_cpu;
    bit [TAG_W-1:0]   start_tag;
    bit [SVC_W-1:0]   start_service;
    bit               was_queued;
    bit               was_dropped;
    bit               went_idle;
    bit               bad_departure;
    bit [DONE_W-1:0]  done_count;
  } outcome_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic                  in_tuser   = 1'b0;  // opcode
  // job_tag[15:0], service_time[47:16], cpu_index[50:48], zero pad
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // start_valid, start_cpu[3:1], start_tag[19:4], start_service[51:20],
  // was_queued[52], was_dropped[53], went_idle[54], bad_departure[55],
  // done_count[71:56]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  multi_cpu_job_dispatcher u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // dispatcher state as predicted
  mode_t          cur_mode = MODE_PER_CPU;
  bit [CNT_W-1:0] cur_cpus = 4'd1;
  bit             cpu_busy [MAX_CPUS];
  bit [JOB_W-1:0] cpu_jobs [MAX_CPUS][CPU_FIFO_DEPTH];
  int             cpu_head [MAX_CPUS];
  int             cpu_fill [MAX_CPUS];
  bit [JOB_W-1:0] shared_jobs [SHARED_FIFO_DEPTH];
  int             shared_head;
  int             shared_fill;
  int             done_cnt [MAX_CPUS];

  outcome_t pending_outcomes [$];
  int err_count;
  int items_sent;
  int results_checked;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int active_cpus();
    if (cur_cpus == 0) return 1;
    if (cur_cpus > MAX_CPUS) return MAX_CPUS;
    return cur_cpus;
  endfunction

  function automatic outcome_t dispatch_outcome(op_t op, bit [TAG_W-1:0] tag,
                                                bit [SVC_W-1:0] svc, bit [CPU_W-1:0] idx);
    outcome_t       o;
    int             n;
    int             slot;
    int             pick;
    bit             have;
    bit [JOB_W-1:0] job;
    bit [JOB_W-1:0] nxt;
    o = '{default: 0};
    n = active_cpus();
    job = {tag, svc};
    nxt = '0;
    have = 1'b0;
    pick = -1;
    if (op == OP_ARRIVAL) begin
      if (cur_mode == MODE_PER_CPU) begin
        if (idx >= n) begin
          o.was_dropped = 1'b1;
        end else if (!cpu_busy[idx]) begin
          cpu_busy[idx] = 1'b1;
          o.start_valid = 1'b1;
          o.start_cpu = idx;
          o.start_tag = tag;
          o.start_service = svc;
        end else if (cpu_fill[idx] >= CPU_FIFO_DEPTH) begin
          o.was_dropped = 1'b1;
        end else begin
          slot = (cpu_head[idx] + cpu_fill[idx]) % CPU_FIFO_DEPTH;
          cpu_jobs[idx][slot] = job;
          cpu_fill[idx]++;
          o.was_queued = 1'b1;
        end
      end else begin
        for (int i = n - 1; i >= 0; i--) if (!cpu_busy[i]) pick = i;
        if (pick >= 0) begin
          cpu_busy[pick] = 1'b1;
          o.start_valid = 1'b1;
          o.start_cpu = CPU_W'(pick);
          o.start_tag = tag;
          o.start_service = svc;
        end else if (shared_fill >= SHARED_FIFO_DEPTH) begin
          o.was_dropped = 1'b1;
        end else begin
          slot = (shared_head + shared_fill) % SHARED_FIFO_DEPTH;
          shared_jobs[slot] = job;
          shared_fill++;
          o.was_queued = 1'b1;
        end
      end
    end else if (idx >= n || !cpu_busy[idx]) begin
      o.bad_departure = 1'b1;
    end else begin
      if (cur_mode == MODE_PER_CPU) begin
        if (cpu_fill[idx] != 0) begin
          nxt = cpu_jobs[idx][cpu_head[idx]];
          cpu_head[idx] = (cpu_head[idx] + 1) % CPU_FIFO_DEPTH;
          cpu_fill[idx]--;
          have = 1'b1;
        end
      end else if (shared_fill != 0) begin
        nxt = shared_jobs[shared_head];
        shared_head = (shared_head + 1) % SHARED_FIFO_DEPTH;
        shared_fill--;
        have = 1'b1;
      end
      if (have) begin
        o.start_valid = 1'b1;
        o.start_cpu = idx;
        o.start_tag = nxt[SVC_W +: TAG_W];
        o.start_service = nxt[SVC_W-1:0];
      end else begin
        cpu_busy[idx] = 1'b0;
        o.went_idle = 1'b1;
      end
      if (done_cnt[idx] < 16'hffff) done_cnt[idx]++;
      o.done_count = DONE_W'(done_cnt[idx]);
    end
    return o;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      err_count++;
      $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  // receiver: stalls, long hold-off and result checking
  always @(posedge clk) begin
    outcome_t              want;
    logic [OUT_DATA_W-1:0] d;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (rst_n && out_tvalid && out_tready) begin
      d = out_tdata;
      results_checked++;
      if (pending_outcomes.size() == 0) begin
        err_count++;
        $error("result with no pending item: %0h", d);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("start_valid", want.start_valid, d[0]);
        check_field("start_cpu", want.start_cpu, d[3:1]);
        check_field("start_tag", want.start_tag, d[19:4]);
        check_field("start_service", want.start_service, d[51:20]);
        check_field("was_queued", want.was_queued, d[52]);
        check_field("was_dropped", want.was_dropped, d[53]);
        check_field("went_idle", want.went_idle, d[54]);
        check_field("bad_departure", want.bad_departure, d[55]);
        check_field("done_count", want.done_count, d[71:56]);
      end
    end
  end

  task automatic send_item(op_t op, bit [TAG_W-1:0] tag, bit [SVC_W-1:0] svc,
                           bit [CPU_W-1:0] idx);
    outcome_t o;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {5'd0, idx, svc, tag};
    do @(posedge clk); while (!in_tready);
    o = dispatch_outcome(op, tag, svc, idx);
    pending_outcomes = {pending_outcomes, o};
    items_sent++;
  endtask

  task automatic arrive(bit [CPU_W-1:0] idx);
    send_item(OP_ARRIVAL, TAG_W'($urandom), $urandom, idx);
  endtask

  task automatic depart(bit [CPU_W-1:0] idx);
    send_item(OP_DEPARTURE, TAG_W'($urandom), $urandom, idx);
  endtask

  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(mode_t m, bit [CNT_W-1:0] cpus);
    cfg_we <= 1'b1;
    cfg_addr <= REG_DISPATCH_MODE;
    cfg_wdata <= {3'($urandom), m};
    @(posedge clk);
    cfg_addr <= REG_CPUS_IN_USE;
    cfg_wdata <= cpus;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
    cur_cpus = cpus;
  endtask

  function automatic bit [CNT_W-1:0] pick_cpu_count();
    case ($urandom_range(5))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd8;
      3: return 4'd15;
      default: return CNT_W'($urandom_range(1, MAX_CPUS));
    endcase
  endfunction

  task automatic send_random_item();
    int             n;
    int             r;
    bit [CPU_W-1:0] busy_list [$];
    bit [CPU_W-1:0] idx;
    n = active_cpus();
    r = $urandom_range(99);
    for (int i = 0; i < n; i++) if (cpu_busy[i]) busy_list = {busy_list, CPU_W'(i)};
    if (r < 8) begin
      send_item(op_t'($urandom_range(1)), TAG_W'($urandom), $urandom,
                CPU_W'($urandom_range(MAX_CPUS - 1)));
    end else if (r < 55 || busy_list.size() == 0) begin
      if ($urandom_range(9) == 0) idx = CPU_W'($urandom_range(MAX_CPUS - 1));
      else idx = CPU_W'($urandom_range(n - 1));
      arrive(idx);
    end else begin
      depart(busy_list[$urandom_range(busy_list.size() - 1)]);
    end
  endtask

  task automatic test_basics();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(OP_ARRIVAL, 16'h0000, 32'h0000_0000, 3'd0);
    send_item(OP_ARRIVAL, 16'hffff, 32'hffff_ffff, 3'd0);
    send_item(OP_ARRIVAL, 16'h5a5a, 32'ha5a5_a5a5, 3'd7);
    depart(3'd0);
    depart(3'd0);
    depart(3'd0);
    depart(3'd7);
    settle_idle();
    write_config(MODE_PER_CPU, 4'd0);
    arrive(3'd1);
    arrive(3'd0);
    depart(3'd0);
    settle_idle();
    write_config(MODE_PER_CPU, 4'd15);
    send_item(OP_ARRIVAL, 16'hffff, 32'hffff_ffff, 3'd7);
    depart(3'd7);
    settle_idle();
    write_config(MODE_SHARED, 4'd8);
    repeat (9) arrive(CPU_W'($urandom_range(7)));
    depart(3'd3);
    depart(3'd3);
  endtask

  // queued jobs stay put across a mode change, cpus above a lowered count stay busy
  task automatic test_mode_switch();
    settle_idle();
    write_config(MODE_PER_CPU, 4'd4);
    repeat (3) arrive(3'd2);
    settle_idle();
    write_config(MODE_SHARED, 4'd2);
    depart(3'd2);
    depart(3'd0);
    arrive(3'd5);
    settle_idle();
    write_config(MODE_PER_CPU, 4'd4);
    depart(3'd2);
    depart(3'd2);
  endtask

  task automatic test_fifo_full();
    send_idle_pct = 24;
    recv_stall_pct = 24;
    settle_idle();
    write_config(MODE_PER_CPU, 4'd8);
    repeat (CPU_FIFO_DEPTH + 2) arrive(3'd5);
    repeat (CPU_FIFO_DEPTH + 2) depart(3'd5);
    settle_idle();
    write_config(MODE_SHARED, 4'd2);
    repeat (SHARED_FIFO_DEPTH + 4) arrive(CPU_W'($urandom_range(7)));
    while (shared_fill > 0 || cpu_busy[0] || cpu_busy[1]) begin
      if (cpu_busy[0] && (!cpu_busy[1] || $urandom_range(1) == 0)) depart(3'd0);
      else depart(3'd1);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    settle_idle();
    write_config(MODE_SHARED, 4'd8);
    hold_left = 300;
    repeat (40) send_random_item();
    settle_idle();
    repeat (20) send_random_item();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int items);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int seg = 0; seg < 4; seg++) begin
      settle_idle();
      write_config(mode_t'($urandom_range(1)), pick_cpu_count());
      repeat (items / 4) send_random_item();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_basics();
    test_mode_switch();
    test_fifo_full();
    test_backpressure();
    test_random_phase(0, 0, 250);
    test_random_phase(75, 0, 250);
    test_random_phase(0, 75, 250);
    test_random_phase(24, 24, 250);
    settle_idle();
    repeat (10) @(posedge clk);
    $display("%0d items driven, %0d results checked", items_sent, results_checked);
    $display("both dispatch modes, cpu counts 0 to 15, full queues, long and random stalls");
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
